[rtl/core/ipg_pkg.sv]
// ----------------------------------------------------------------------------
// ipg_pkg
// Shared constants and types for the integer partition generator.
// ----------------------------------------------------------------------------
package ipg_pkg;

  localparam int MAX_NUMBER = 16;
  localparam int VAL_W      = 5;
  localparam int CNT_W      = $clog2(MAX_NUMBER + 1);
  localparam int IDX_W      = $clog2(MAX_NUMBER);

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic ge;
    logic zero;
  } alu_flags_t;

endpackage

[rtl/core/integer_partition_generator.sv]
// ----------------------------------------------------------------------------
// integer_partition_generator
// Lists the partitions of a number in reverse lexicographic order, one
// partition per advance command, one part per result beat.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------
//  command  | start / busy     | mode, target_number
//  result   | strobe (1 cycle) | part_value, last_part, finished
//
//  Start: loads the target as the only part, then issues its one part beat.
//  Advance: reads each part from the end (trailing ones and the part above
//  one), lowers that part, refills copies of it plus any remainder, then
//  issues one beat per part; the scan/refill loop runs through the shared
//  add/subtract unit and the one-read-port part store.
//  Synchronous reset; no partition is held after reset.
//  Results cannot be stalled; busy stays high until the last beat is issued.
// ----------------------------------------------------------------------------
module integer_partition_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [4:0]                    target_number,
  output logic                          strobe,
  output logic [ipg_pkg::VAL_W-1:0]     part_value,
  output logic                          last_part,
  output logic                          finished
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_LOWER,
    S_BUMP,
    S_FILL,
    S_EMIT
  } state_t;

  localparam logic [ipg_pkg::CNT_W-1:0] CNT_MAX = ipg_pkg::CNT_W'(ipg_pkg::MAX_NUMBER);
  localparam logic [ipg_pkg::VAL_W-1:0] VAL_MAX = ipg_pkg::VAL_W'(ipg_pkg::MAX_NUMBER);
  localparam logic [ipg_pkg::VAL_W-1:0] VAL_ONE = ipg_pkg::VAL_W'(1);

  state_t                       state;
  logic [ipg_pkg::IDX_W-1:0]    pos;
  logic [ipg_pkg::VAL_W-1:0]    sum;
  logic [ipg_pkg::VAL_W-1:0]    value;
  logic [ipg_pkg::CNT_W-1:0]    count;
  logic [ipg_pkg::CNT_W-1:0]    part_count;
  logic [ipg_pkg::CNT_W-1:0]    idx;
  logic                         active;
  logic                         emit_pend;
  logic                         emit_last_pend;

  logic                         we;
  logic [ipg_pkg::IDX_W-1:0]    waddr;
  logic [ipg_pkg::VAL_W-1:0]    wdata;
  logic [ipg_pkg::IDX_W-1:0]    raddr;
  logic [ipg_pkg::VAL_W-1:0]    rdata;

  ipg_pkg::alu_op_t             alu_op;
  logic [ipg_pkg::VAL_W-1:0]    alu_a;
  logic [ipg_pkg::VAL_W-1:0]    alu_b;
  logic [ipg_pkg::VAL_W-1:0]    alu_res;
  ipg_pkg::alu_flags_t          alu_flags;

  logic [ipg_pkg::VAL_W-1:0]    target_clamped;
  logic                         accept;
  logic                         room;

  assign busy   = (state != S_IDLE) || emit_pend;
  assign accept = start && !busy;
  assign room   = (count < CNT_MAX);

  always_comb begin
    if (target_number == '0) begin
      target_clamped = VAL_ONE;
    end else if (target_number > VAL_MAX) begin
      target_clamped = VAL_MAX;
    end else begin
      target_clamped = target_number;
    end
  end

  ipg_ram #(
    .WIDTH (ipg_pkg::VAL_W),
    .DEPTH (ipg_pkg::MAX_NUMBER)
  ) u_parts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ipg_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  always_comb begin
    alu_op = ipg_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_CHK: begin
        alu_a = sum;
        alu_b = rdata;
      end
      S_LOWER: begin
        alu_op = ipg_pkg::ALU_SUB;
        alu_a  = value;
        alu_b  = VAL_ONE;
      end
      S_BUMP: begin
        alu_a = sum;
        alu_b = VAL_ONE;
      end
      S_FILL: begin
        alu_op = ipg_pkg::ALU_SUB;
        alu_a  = sum;
        alu_b  = value;
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && mode == ipg_pkg::MODE_START) begin
          we    = 1'b1;
          wdata = target_clamped;
        end
      end
      S_RD: raddr = pos;
      S_LOWER: begin
        we    = 1'b1;
        waddr = pos;
        wdata = alu_res;
      end
      S_FILL: begin
        waddr = count[ipg_pkg::IDX_W-1:0];
        if (room && alu_flags.ge) begin
          we    = 1'b1;
          wdata = value;
        end else if (room && !alu_flags.zero) begin
          we    = 1'b1;
          wdata = sum;
        end
      end
      S_EMIT: raddr = idx[ipg_pkg::IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= 1'b0;
      part_count <= '0;
      emit_pend  <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      emit_pend <= 1'b0;
      if (emit_pend) begin
        strobe     <= 1'b1;
        part_value <= rdata;
        last_part  <= emit_last_pend;
        finished   <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == ipg_pkg::MODE_START) begin
              part_count <= ipg_pkg::CNT_W'(1);
              active     <= 1'b1;
              idx        <= '0;
              state      <= S_EMIT;
            end else if (!active || part_count == '0) begin
              active     <= 1'b0;
              strobe     <= 1'b1;
              part_value <= '0;
              last_part  <= 1'b0;
              finished   <= 1'b1;
            end else begin
              pos   <= ipg_pkg::IDX_W'(part_count - ipg_pkg::CNT_W'(1));
              sum   <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (rdata > VAL_ONE) begin
            value <= rdata;
            state <= S_LOWER;
          end else begin
            sum <= alu_res;
            if (pos == '0) begin
              // all ones: sequence is done
              active     <= 1'b0;
              strobe     <= 1'b1;
              part_value <= '0;
              last_part  <= 1'b0;
              finished   <= 1'b1;
              state      <= S_IDLE;
            end else begin
              pos   <= pos - ipg_pkg::IDX_W'(1);
              state <= S_RD;
            end
          end
        end
        S_LOWER: begin
          value <= alu_res;
          count <= ipg_pkg::CNT_W'(pos) + ipg_pkg::CNT_W'(1);
          state <= S_BUMP;
        end
        S_BUMP: begin
          sum   <= alu_res;
          state <= S_FILL;
        end
        S_FILL: begin
          if (room && alu_flags.ge) begin
            sum   <= alu_res;
            count <= count + ipg_pkg::CNT_W'(1);
          end else begin
            if (room && !alu_flags.zero) begin
              part_count <= count + ipg_pkg::CNT_W'(1);
            end else begin
              part_count <= count;
            end
            idx   <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          emit_pend      <= 1'b1;
          emit_last_pend <= (idx == part_count - ipg_pkg::CNT_W'(1));
          if (idx == part_count - ipg_pkg::CNT_W'(1)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + ipg_pkg::CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fin_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(finished && last_part))
    else $error("finished beat flagged as last part");

  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && finished) |-> (part_value == '0))
    else $error("finished beat carries a nonzero part");

  a_parts_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !finished && !last_part) |=> strobe)
    else $error("gap inside a partition's beats");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == ipg_pkg::MODE_START) |=> busy)
    else $error("start command did not raise busy");
`endif

endmodule

[rtl/core/ipg_ram.sv]
// ----------------------------------------------------------------------------
// ipg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ipg_alu.sv]
// ----------------------------------------------------------------------------
// ipg_alu
// Shared add/subtract unit with compare and zero flags, reused by the scan, lower, bump and fill steps.
// ----------------------------------------------------------------------------
module ipg_alu (
  input  ipg_pkg::alu_op_t              op,
  input  logic [ipg_pkg::VAL_W-1:0]     a,
  input  logic [ipg_pkg::VAL_W-1:0]     b,
  output logic [ipg_pkg::VAL_W-1:0]     res,
  output ipg_pkg::alu_flags_t           flags
);

  always_comb begin
    case (op)
      ipg_pkg::ALU_ADD: res = a + b;
      ipg_pkg::ALU_SUB: res = a - b;
      default:          res = a + b;
    endcase
    flags.ge   = (a >= b);
    flags.zero = (a == '0);
  end

endmodule

[verif/integer_partition_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_partition_generator_tb
// Drives start and advance commands into the partition generator and tracks
// the stored partition in a local predictor. Every part beat is checked in
// order against the queued parts of the predicted partition. Directed tests
// cover advance before start, target clamping, restart mid-sequence and a
// full enumeration. Random runs follow, with bursty command timing.
// ----------------------------------------------------------------------------
module integer_partition_generator_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ipg_pkg::VAL_W-1:0] value;
    logic                      last;
    logic                      done;
  } part_beat_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      mode;
  logic [4:0]                target_number;
  logic                      strobe;
  logic [ipg_pkg::VAL_W-1:0] part_value;
  logic                      last_part;
  logic                      finished;

  integer_partition_generator dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .target_number (target_number),
    .strobe        (strobe),
    .part_value    (part_value),
    .last_part     (last_part),
    .finished      (finished)
  );

  part_beat_t                pending_parts[$];
  logic [ipg_pkg::VAL_W-1:0] part_store[ipg_pkg::MAX_NUMBER];
  int                        part_total;
  bit                        run_live;
  int                        errors;
  int                        cycles;
  int                        burst_left;
  int                        max_gap;
  int                        cmds_sent;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Next partition in reverse lexicographic order; queues its part beats.
  task automatic predict_partition(input logic m, input logic [4:0] t);
    int pos;
    int sum;
    int val;
    int copies;
    int rem;
    int cnt;
    int k;
    logic [4:0] n;
    if (m == ipg_pkg::MODE_START) begin
      n = t;
      if (n == 0) n = 1;
      if (n > ipg_pkg::MAX_NUMBER) n = ipg_pkg::MAX_NUMBER;
      part_store[0] = n;
      part_total    = 1;
      run_live      = 1'b1;
    end else begin
      if (!run_live || part_total == 0 || part_total > ipg_pkg::MAX_NUMBER) begin
        run_live = 1'b0;
        pending_parts.push_back('{value: '0, last: 1'b0, done: 1'b1});
        return;
      end
      sum = 0;
      for (pos = part_total - 1; pos >= 0; pos--) begin
        if (part_store[pos] > 1) break;
        sum += part_store[pos];
      end
      if (pos < 0) begin
        run_live = 1'b0;
        pending_parts.push_back('{value: '0, last: 1'b0, done: 1'b1});
        return;
      end
      val = part_store[pos] - 1;
      part_store[pos] = val;
      sum += 1;
      copies = sum / val;
      rem    = sum % val;
      cnt    = pos + 1;
      for (k = 0; k < copies && cnt < ipg_pkg::MAX_NUMBER; k++) begin
        part_store[cnt] = val;
        cnt++;
      end
      if (rem != 0 && cnt < ipg_pkg::MAX_NUMBER) begin
        part_store[cnt] = rem;
        cnt++;
      end
      part_total = cnt;
    end
    for (k = 0; k < part_total; k++)
      pending_parts.push_back('{value: part_store[k], last: (k == part_total - 1),
                                done: 1'b0});
  endtask

  // One command beat; start stays high across back-to-back beats.
  task automatic send_cmd(input logic m, input logic [4:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    start         <= 1'b1;
    mode          <= m;
    target_number <= t;
    do @(posedge clk); while (busy);
    predict_partition(m, t);
    burst_left--;
    cmds_sent++;
  endtask

  always @(posedge clk) begin
    part_beat_t want;
    if (!rst && strobe) begin
      if (pending_parts.size() == 0) begin
        $display("%0t: unexpected beat: value %0d last %0d finished %0d",
                 $time, part_value, last_part, finished);
        errors++;
      end else begin
        want = pending_parts.pop_front();
        if (part_value !== want.value || last_part !== want.last ||
            finished !== want.done) begin
          $display({"%0t: mismatch: expected value %0d last %0d finished %0d,",
                    " got value %0d last %0d finished %0d"},
                   $time, want.value, want.last, want.done,
                   part_value, last_part, finished);
          errors++;
        end
      end
    end
  end

  task automatic test_advance_before_start();
    max_gap = 3;
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd0);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd31);
  endtask

  task automatic test_target_extremes();
    max_gap = 0;
    send_cmd(ipg_pkg::MODE_START, 5'd0);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd0);
    send_cmd(ipg_pkg::MODE_START, 5'd31);
    send_cmd(ipg_pkg::MODE_START, 5'd17);
    send_cmd(ipg_pkg::MODE_START, 5'd16);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd10);
    send_cmd(ipg_pkg::MODE_START, 5'd1);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd21);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd1);
  endtask

  task automatic test_restart_midway();
    max_gap = 5;
    send_cmd(ipg_pkg::MODE_START, 5'd5);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd0);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd0);
    send_cmd(ipg_pkg::MODE_START, 5'd3);
    send_cmd(ipg_pkg::MODE_ADVANCE, 5'd0);
  endtask

  task automatic test_full_enumeration();
    max_gap = 2;
    send_cmd(ipg_pkg::MODE_START, 5'd5);
    repeat (7) send_cmd(ipg_pkg::MODE_ADVANCE, 5'($urandom_range(0, 31)));
  endtask

  task automatic test_random_runs(input int goal);
    int sel;
    int n;
    int steps;
    logic [4:0] t;
    while (cmds_sent < goal) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 9) < 8) begin
        sel = $urandom_range(0, 9);
        if (sel < 7)       t = 5'($urandom_range(1, 8));
        else if (sel < 9)  t = 5'($urandom_range(9, 16));
        else               t = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
        send_cmd(ipg_pkg::MODE_START, t);
        if (part_store[0] <= 10 && $urandom_range(0, 4) < 3) begin
          while (run_live) send_cmd(ipg_pkg::MODE_ADVANCE, 5'($urandom_range(0, 31)));
          repeat ($urandom_range(0, 2))
            send_cmd(ipg_pkg::MODE_ADVANCE, 5'($urandom_range(0, 31)));
        end else begin
          steps = $urandom_range(1, 25);
          repeat (steps) send_cmd(ipg_pkg::MODE_ADVANCE, 5'($urandom_range(0, 31)));
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_cmd(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    mode          = ipg_pkg::MODE_START;
    target_number = '0;
    errors        = 0;
    cycles        = 0;
    burst_left    = 0;
    max_gap       = 0;
    cmds_sent     = 0;
    part_total    = 0;
    run_live      = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_advance_before_start();
    test_target_extremes();
    test_restart_midway();
    test_full_enumeration();
    test_random_runs(360);

    start <= 1'b0;
    while (pending_parts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_parts.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
